// ----- design/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BLZD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");

// Condition must never be seen outside reset.
`define BLZD_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");

`endif

// ----- design/blzd_pkg.sv -----
`default_nettype none
package blzd_pkg;

	// output history
	localparam int HIST_DEPTH = 4098;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int HIST_CW    = $clog2(HIST_DEPTH + 1);

	// command queue between front and back
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

	// match encoding
	localparam int MATCH_BIAS = 3;
	localparam int MAX_LEN    = 18;
	localparam int LEN_W      = 5;

	// command kinds
	localparam logic [1:0] CMD_LIT   = 2'd0;
	localparam logic [1:0] CMD_MATCH = 2'd1;
	localparam logic [1:0] CMD_FLUSH = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] data;
		logic        fin;
	} blzd_cmd_t;

endpackage
`default_nettype wire

// ----- design/blzd_front.sv -----
`default_nettype none
module blzd_front
	import blzd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // comp_byte
	input  wire logic       s_axis_tlast,  // final_byte
	input  wire logic       q_full,
	output logic            push,
	output blzd_cmd_t       push_cmd
);

	logic [7:0] flag_bits_q;
	logic [3:0] flags_left_q;
	logic [7:0] match_high_q;
	logic       awaiting_q;

	logic       accept;
	logic       emit;
	logic       consume;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// classify the byte against the token state
	always_comb begin
		emit          = 1'b0;
		consume       = 1'b0;
		push_cmd.kind = CMD_FLUSH;
		push_cmd.data = {8'd0, s_axis_tdata};
		push_cmd.fin  = s_axis_tlast;
		if (awaiting_q) begin
			emit          = 1'b1;
			consume       = 1'b1;
			push_cmd.kind = CMD_MATCH;
			push_cmd.data = {match_high_q, s_axis_tdata};
		end else if (flags_left_q == 4'd0) begin
			emit = 1'b0;
		end else if (!flag_bits_q[7]) begin
			emit          = 1'b1;
			consume       = 1'b1;
			push_cmd.kind = CMD_LIT;
		end
		// a final byte that yields nothing still has to clear the history
		push = accept && (emit || s_axis_tlast);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_bits_q  <= '0;
			flags_left_q <= '0;
			match_high_q <= '0;
			awaiting_q   <= 1'b0;
		end else if (accept) begin
			if (s_axis_tlast) begin
				flag_bits_q  <= '0;
				flags_left_q <= '0;
				match_high_q <= '0;
				awaiting_q   <= 1'b0;
			end else if (awaiting_q) begin
				awaiting_q <= 1'b0;
			end else if (flags_left_q == 4'd0) begin
				flag_bits_q  <= s_axis_tdata;
				flags_left_q <= 4'd8;
			end else if (flag_bits_q[7]) begin
				match_high_q <= s_axis_tdata;
				awaiting_q   <= 1'b1;
			end
			if (consume && !s_axis_tlast) begin
				flag_bits_q <= {flag_bits_q[6:0], 1'b0};
				if (flags_left_q != 4'd0) begin
					flags_left_q <= flags_left_q - 4'd1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/blzd_cmdq.sv -----
`default_nettype none
module blzd_cmdq
	import blzd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire blzd_cmd_t push_cmd,
	input  wire logic      pop,
	output logic           full,
	output logic           empty,
	output blzd_cmd_t      head
);

	blzd_cmd_t            slot_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0]   wr_ptr_q;
	logic [CMDQ_AW-1:0]   rd_ptr_q;
	logic [CMDQ_AW:0]     count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (count_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
	assign empty   = (count_q == '0);
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- design/blzd_back.sv -----
`default_nettype none
`include "assert_macros.svh"
module blzd_back
	import blzd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cmd_valid,
	input  wire blzd_cmd_t  cmd,
	output logic            pop,
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,
	output logic            m_axis_tlast,
	output logic [0:0]      m_axis_tuser
);

	localparam logic [HIST_AW-1:0] LAST_IDX = HIST_AW'(HIST_DEPTH - 1);
	localparam logic [HIST_AW:0]   DEPTH_X  = (HIST_AW+1)'(HIST_DEPTH);
	localparam logic [HIST_CW-1:0] FULL_CNT = HIST_CW'(HIST_DEPTH);

	logic [7:0] hist_mem [HIST_DEPTH];
	logic [7:0] rdata_q;

	logic               busy_q;
	logic [LEN_W-1:0]   len_q;
	logic [HIST_AW-1:0] src_q;
	logic               fin_q;
	logic [HIST_AW-1:0] ipos_q;
	logic [HIST_CW-1:0] icount_q;

	logic               s1_valid_q;
	logic [HIST_AW-1:0] s1_addr_s1;
	logic               s1_lit_s1;
	logic               s1_zero_s1;
	logic [7:0]         s1_byte_s1;
	logic               s1_last_s1;
	logic               s1_done_s1;
	logic [7:0]         s1_data;

	logic               out_free;
	logic               adv;
	logic               issue;
	logic               issue_lit;
	logic               start_match;
	logic               flush;
	logic               issue_last;
	logic               issue_fin;
	logic               rd_hit;
	logic [12:0]        copy_dist;
	logic [HIST_AW:0]   src_sum;
	logic [HIST_AW-1:0] src0;

	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign adv      = !s1_valid_q || out_free;

	// start of copy, wrapped once into the history
	assign copy_dist = {1'b0, cmd.data[11:0]} + 13'(MATCH_BIAS);
	assign src_sum   = {1'b0, ipos_q} + (DEPTH_X - (HIST_AW+1)'(copy_dist));
	assign src0    = (src_sum >= DEPTH_X) ? HIST_AW'(src_sum - DEPTH_X) : src_sum[HIST_AW-1:0];

	// slots below the issue count have been written since the stream began
	assign rd_hit = ({1'b0, src_q} < (HIST_AW+1)'(icount_q));

	always_comb begin
		issue       = 1'b0;
		issue_lit   = 1'b0;
		pop         = 1'b0;
		start_match = 1'b0;
		flush       = 1'b0;
		if (adv) begin
			if (busy_q) begin
				issue = 1'b1;
			end else if (cmd_valid) begin
				pop = 1'b1;
				case (cmd.kind)
					CMD_LIT: begin
						issue     = 1'b1;
						issue_lit = 1'b1;
					end
					CMD_MATCH: start_match = 1'b1;
					CMD_FLUSH: flush = 1'b1;
					default:   flush = 1'b0;
				endcase
			end
		end
		issue_last = issue_lit || (len_q == LEN_W'(1));
		issue_fin  = issue_lit ? cmd.fin : fin_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			len_q    <= '0;
			src_q    <= '0;
			fin_q    <= 1'b0;
			ipos_q   <= '0;
			icount_q <= '0;
		end else begin
			if (start_match) begin
				busy_q <= 1'b1;
				len_q  <= {1'b0, cmd.data[15:12]} + LEN_W'(MATCH_BIAS);
				src_q  <= src0;
				fin_q  <= cmd.fin;
			end
			if (issue && !issue_lit) begin
				len_q <= len_q - LEN_W'(1);
				src_q <= (src_q == LAST_IDX) ? '0 : src_q + 1'b1;
				if (len_q == LEN_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
			if (flush || (issue && issue_last && issue_fin)) begin
				ipos_q   <= '0;
				icount_q <= '0;
			end else if (issue) begin
				ipos_q <= (ipos_q == LAST_IDX) ? '0 : ipos_q + 1'b1;
				if (icount_q != FULL_CNT) begin
					icount_q <= icount_q + 1'b1;
				end
			end
		end
	end

	// read port: one source byte per issued copy step
	always_ff @(posedge clk) begin
		if (issue && !issue_lit) begin
			rdata_q <= hist_mem[src_q];
		end
	end

	assign s1_data = s1_lit_s1 ? s1_byte_s1 : (s1_zero_s1 ? 8'd0 : rdata_q);

	// write port: a byte enters the history as it moves to the output
	always_ff @(posedge clk) begin
		if (s1_valid_q && out_free) begin
			hist_mem[s1_addr_s1] <= s1_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid_q <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			s1_addr_s1 <= ipos_q;
			s1_lit_s1  <= issue_lit;
			s1_zero_s1 <= !issue_lit && !rd_hit;
			s1_byte_s1 <= cmd.data[7:0];
			s1_last_s1 <= issue_last;
			s1_done_s1 <= issue_last && issue_fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_free) begin
			m_axis_tvalid <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_valid_q) begin
			m_axis_tdata    <= s1_data;
			m_axis_tlast    <= s1_last_s1;
			m_axis_tuser[0] <= s1_done_s1;
		end
	end

	`BLZD_ASSERT(a_len_range, clk, arst_n, !busy_q || (len_q != '0 && len_q <= LEN_W'(MAX_LEN)))
	`BLZD_ASSERT(a_count_cap, clk, arst_n, icount_q <= FULL_CNT)
	`BLZD_NEVER(a_ptr_range, clk, arst_n, ipos_q > LAST_IDX || src_q > LAST_IDX)
	`BLZD_ASSERT(a_s1_hold, clk, arst_n, (s1_valid_q && !out_free) |=> (s1_valid_q && $stable(s1_addr_s1)))

endmodule
`default_nettype wire

// ----- design/backward_lzss_decompressor_core.sv -----
// Backward LZSS decompressor: takes compressed token bytes on s_axis in the
// order a backward decoder reads them (descending address) and returns the
// decompressed bytes on m_axis, also in descending address order. tlast on
// the input marks the final compressed byte; after it the token state and
// the 4098-byte output history return to their reset contents, so the next
// byte opens a fresh stream. On the output, tlast marks the last byte caused
// by one input byte and tuser[0] the last byte of the whole stream. A match
// copies its 3 to 18 bytes one at a time, since the history memory yields
// one source byte per cycle while the output is not stalled. The front
// parses tokens into a four-entry command queue, so input keeps flowing
// while a copy is under way. No clearing pass follows reset: a count of
// bytes written since the stream began marks which history slots are live,
// and any other slot reads zero.
`default_nettype none
module backward_lzss_decompressor_core
	import blzd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] comp_byte
	input  wire logic       s_axis_tlast,  // final_byte
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // [7:0] out_byte
	output logic            m_axis_tlast,  // last_of_run
	output logic [0:0]      m_axis_tuser   // [0] stream_done
);

	// front to queue
	logic      push;
	blzd_cmd_t push_cmd;
	logic      q_full;

	// queue to back
	logic      q_empty;
	logic      pop;
	blzd_cmd_t head;

	// Front: accept a transfer whenever the queue has room, track the flag
	// byte and pending match high byte, and hand literals, matches and
	// end-of-stream flushes on as commands.
	blzd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (q_full),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	// Queue: decouple parsing from the byte-per-cycle copy engine.
	blzd_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	// Back: drain commands, read the history one byte per cycle while the output
	// is not stalled, write each produced byte back into it and hold results in
	// the output register until the downstream transfer completes.
	blzd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (!q_empty),
		.cmd           (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
`default_nettype wire

// ----- tb/tb_backward_lzss_decompressor_core.sv -----
`timescale 1ns / 100ps
module tb_backward_lzss_decompressor_core;
	import blzd_pkg::*;

	// one decompressed byte as it leaves m_axis
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       done;
	} out_beat_t;

	// directed row: input byte, end of stream, and a hand-written expectation
	// (count of identical bytes) where typed is set
	typedef struct packed {
		logic [7:0] b;
		logic       fin;
		logic       typed;
		logic [4:0] n;
		logic [7:0] v;
	} stim_row_t;

	typedef enum int {
		KIND_WHOLE,
		KIND_CUT_FLAG,
		KIND_CUT_MATCH,
		KIND_NOISE,
		KIND_WRAP
	} stream_kind_t;

	localparam int DIRECTED_ROWS = 24;
	localparam int RANDOM_ITEMS  = 350;
	localparam int HOLD_CYCLES   = 300;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;
	logic [0:0] m_axis_tuser;

	// decoder image: output history and token state
	logic [7:0] hist_mem [HIST_DEPTH];
	int         hist_wr;
	logic [7:0] flag_reg;
	int         flags_rem;
	logic [7:0] hi_byte;
	bit         want_low;
	out_beat_t  fresh [MAX_LEN];

	out_beat_t  decoded_q [$];
	int         fail_count = 0;
	int         items_sent = 0;
	int         burst_left = 0;
	bit         hold_req = 1'b0;
	stim_row_t  dir_rows [DIRECTED_ROWS];

	backward_lzss_decompressor_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #1 clk = ~clk;

	task automatic clear_decoder();
		int i;
		for (i = 0; i < HIST_DEPTH; i++) hist_mem[i] = 8'h00;
		hist_wr   = 0;
		flag_reg  = 8'h00;
		flags_rem = 0;
		hi_byte   = 8'h00;
		want_low  = 1'b0;
	endtask

	// record a byte in the history and in the result list
	task automatic put_byte(input logic [7:0] b, inout int n);
		hist_mem[hist_wr] = b;
		hist_wr = (hist_wr + 1) % HIST_DEPTH;
		fresh[n].data = b;
		fresh[n].last = 1'b0;
		fresh[n].done = 1'b0;
		n++;
	endtask

	// advance the token state by one compressed byte; fills fresh[0:n-1]
	task automatic decode_token(input logic [7:0] b, input logic fin, output int n);
		logic [15:0] word;
		int          len;
		int          copy_dist;
		int          i;
		n = 0;
		if (want_low) begin
			word      = {hi_byte, b};
			len       = word[15:12] + MATCH_BIAS;
			copy_dist = word[11:0] + MATCH_BIAS;
			// copy one byte at a time so that a copy may feed itself
			for (i = 0; i < len; i++)
				put_byte(hist_mem[(hist_wr + HIST_DEPTH - copy_dist) % HIST_DEPTH], n);
			want_low = 1'b0;
			flag_reg = flag_reg << 1;
			flags_rem--;
		end else if (flags_rem == 0) begin
			flag_reg  = b;
			flags_rem = 8;
		end else if (flag_reg[7]) begin
			hi_byte  = b;
			want_low = 1'b1;
		end else begin
			put_byte(b, n);
			flag_reg = flag_reg << 1;
			flags_rem--;
		end
		if (n > 0) begin
			fresh[n - 1].last = 1'b1;
			fresh[n - 1].done = fin;
		end
		if (fin) clear_decoder();
	endtask

	// offer one byte in bursts with random gaps; entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
		input int t_n, input logic [7:0] t_b);
		int        gap;
		int        n;
		int        i;
		out_beat_t beat;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= fin;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		decode_token(b, fin, n);
		if (typed) begin
			for (i = 0; i < t_n; i++) begin
				beat.data = t_b;
				beat.last = (i == t_n - 1);
				beat.done = fin && (i == t_n - 1);
				decoded_q.push_back(beat);
			end
		end else begin
			for (i = 0; i < n; i++) decoded_q.push_back(fresh[i]);
		end
		@(negedge clk);
	endtask

	// build one stream of tokens and send it with tlast on its final byte
	task automatic send_stream(input int tokens, input stream_kind_t kind);
		logic [7:0] sq [$];
		logic [7:0] flags;
		logic [7:0] hi;
		logic [7:0] lo;
		int         flag_at;
		int         t;
		if (kind == KIND_NOISE) begin
			for (t = 0; t < tokens; t++) sq.push_back(8'($urandom));
		end else begin
			for (t = 0; t < tokens; t++) begin
				if (t % 8 == 0) begin
					flags   = (kind == KIND_WRAP) ? 8'hff : 8'($urandom);
					flag_at = sq.size();
					sq.push_back(flags);
				end
				// force a match on the final token of a stream cut mid-match
				if (kind == KIND_CUT_MATCH && t == tokens - 1) begin
					flags[7 - t % 8] = 1'b1;
					sq[flag_at] = flags;
				end
				if (flags[7 - t % 8]) begin
					hi = 8'($urandom);
					lo = 8'($urandom);
					if (kind == KIND_WRAP) begin
						hi[7:4] = 4'hf;
					end else if ($urandom_range(0, 1)) begin
						// near copies reach bytes actually written in this stream
						hi[3:0] = 4'h0;
						lo = 8'($urandom_range(0, 40));
					end
					sq.push_back(hi);
					sq.push_back(lo);
				end else begin
					sq.push_back(8'($urandom));
				end
			end
			if (kind == KIND_CUT_MATCH) void'(sq.pop_back());
			if (kind == KIND_CUT_FLAG) sq.push_back(8'($urandom));
		end
		foreach (sq[k]) send_byte(sq[k], k == sq.size() - 1, 1'b0, 0, 8'h00);
	endtask

	task automatic note_fail(input string what, input int exp_v, input int got_v);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch in %s: expected %0h, got %0h at %0t ns",
				what, exp_v, got_v, $realtime);
	endtask

	// check each transfer on m_axis against the oldest pending byte
	always @(posedge clk) begin : check_out
		out_beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (decoded_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected output byte %0h at %0t ns", m_axis_tdata, $realtime);
			end else begin
				want = decoded_q.pop_front();
				if (m_axis_tdata !== want.data) note_fail("out_byte", want.data, m_axis_tdata);
				if (m_axis_tlast !== want.last) note_fail("last_of_run", want.last, m_axis_tlast);
				if (m_axis_tuser[0] !== want.done)
					note_fail("stream_done", want.done, m_axis_tuser[0]);
			end
		end
	end

	// receiver: changing stall patterns, plus one long hold-off to fill the block
	initial begin : sink_pattern
		int  mode;
		int  span;
		int  k;
		bit  hold_done;
		hold_done = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 64);
			for (k = 0; k < span; k++) begin
				@(negedge clk);
				if (hold_req && !hold_done) begin
					m_axis_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
					hold_done = 1'b1;
				end
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= (k % 4 == 0);
					default: m_axis_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		int i;
		int pick;
		dir_rows = '{
			'{8'h80, 1'b0, 1'b1, 5'd0,  8'h00},  // flag byte: first token a match
			'{8'hff, 1'b0, 1'b1, 5'd0,  8'h00},  // match high byte, longest length
			'{8'hff, 1'b0, 1'b1, 5'd18, 8'h00},  // farthest copy before any output
			'{8'hab, 1'b0, 1'b1, 5'd1,  8'hab},
			'{8'h00, 1'b0, 1'b1, 5'd1,  8'h00},
			'{8'hff, 1'b0, 1'b1, 5'd1,  8'hff},
			'{8'h01, 1'b0, 1'b1, 5'd1,  8'h01},
			'{8'h02, 1'b0, 1'b1, 5'd1,  8'h02},
			'{8'h80, 1'b0, 1'b1, 5'd1,  8'h80},
			'{8'h7f, 1'b0, 1'b1, 5'd1,  8'h7f},
			'{8'hff, 1'b0, 1'b1, 5'd0,  8'h00},  // flag byte: eight matches
			'{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},
			'{8'h00, 1'b0, 1'b0, 5'd0,  8'h00},  // shortest, nearest copy
			'{8'h10, 1'b0, 1'b1, 5'd0,  8'h00},
			'{8'h00, 1'b0, 1'b0, 5'd0,  8'h00},  // copy overlapping its own output
			'{8'hf0, 1'b0, 1'b1, 5'd0,  8'h00},
			'{8'h00, 1'b0, 1'b0, 5'd0,  8'h00},  // longest copy, heavy overlap
			'{8'h12, 1'b1, 1'b1, 5'd0,  8'h00},  // stream ends mid-match
			'{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},  // fresh stream, all literals
			'{8'h55, 1'b1, 1'b1, 5'd1,  8'h55},  // literal closes the stream
			'{8'h3c, 1'b1, 1'b1, 5'd0,  8'h00},  // stream ends on a flag byte
			'{8'h80, 1'b0, 1'b1, 5'd0,  8'h00},
			'{8'h0f, 1'b0, 1'b1, 5'd0,  8'h00},
			// reaches slots the first stream wrote: cleared history reads zero
			'{8'hed, 1'b1, 1'b1, 5'd3,  8'h00}
		};
		clear_decoder();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tlast  = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < DIRECTED_ROWS; i++)
			send_byte(dir_rows[i].b, dir_rows[i].fin, dir_rows[i].typed,
				dir_rows[i].n, dir_rows[i].v);

		// mostly well-formed streams, some cut short, some pure noise
		hold_req = 1'b1;
		while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 19);
			if (pick < 14)      send_stream($urandom_range(1, 40), KIND_WHOLE);
			else if (pick < 16) send_stream(8 * $urandom_range(1, 3), KIND_CUT_FLAG);
			else if (pick < 18) send_stream($urandom_range(1, 24), KIND_CUT_MATCH);
			else                send_stream($urandom_range(1, 20), KIND_NOISE);
		end
		// one long stream of longest copies so the history wraps around
		send_stream(240, KIND_WRAP);
		s_axis_tvalid <= 1'b0;

		while (decoded_q.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (fail_count == 0 && decoded_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+design
design/blzd_pkg.sv
design/blzd_front.sv
design/blzd_cmdq.sv
design/blzd_back.sv
design/backward_lzss_decompressor_core.sv
tb/tb_backward_lzss_decompressor_core.sv
